// ===== src/vdit_pkg.sv =====
`default_nettype none
package vdit_pkg;

  // Default number of key table entries
  localparam int unsigned TABLE_CAPACITY_DEF = 256;

  // Width of the coordinate fields and of the result index
  localparam int unsigned COORD_W = 64;
  localparam int unsigned INDEX_W = 8;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch the key, rewind the scan
    logic scan;    // issue the next table read, compare the last one
    logic finish;  // load the result register, insert on a miss with room
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic match;      // registered entry equals the key
    logic scan_done;  // all used entries read and compared
    logic out_free;   // result register can take a beat
  } dp_status_t;

endpackage
`default_nettype wire

// ===== src/vdit_vertex_if.sv =====
`default_nettype none
interface vdit_vertex_if;
  import vdit_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                output ready);
endinterface
`default_nettype wire

// ===== src/vdit_result_if.sv =====
`default_nettype none
interface vdit_result_if;
  import vdit_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] vertex_index;
  logic               was_new;
  logic               overflow;

  modport source (output valid, output vertex_index, output was_new, output overflow,
                  input ready);
  modport sink (input valid, input vertex_index, input was_new, input overflow,
                output ready);
endinterface
`default_nettype wire

// ===== src/vdit_ctrl.sv =====
`default_nettype none
module vdit_ctrl
  import vdit_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one vertex: scan the table, then deliver the result
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.match || status.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/vdit_datapath.sv =====
`default_nettype none
module vdit_datapath
  import vdit_pkg::*;
#(
  parameter int unsigned TABLE_CAPACITY = TABLE_CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [COORD_W-1:0] coord_x,
  input  wire logic [COORD_W-1:0] coord_y,
  input  wire logic [COORD_W-1:0] coord_z,
  input  wire dp_cmd_t            cmd,
  output dp_status_t              status,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [INDEX_W-1:0]      vertex_index,
  output logic                    was_new,
  output logic                    overflow
);

  localparam int unsigned IDX_W = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_CAPACITY + 1);
  localparam int unsigned EXT_W = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int unsigned KEY_W = 3 * COORD_W;

  logic [KEY_W-1:0] key_table [TABLE_CAPACITY];

  logic [KEY_W-1:0] key;
  logic [KEY_W-1:0] rd_data;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] used_count;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;

  logic             match;
  logic             more;
  logic             full;
  logic             insert;
  logic [IDX_W-1:0] res_idx;
  logic [EXT_W-1:0] res_ext;

  assign match  = rd_valid && (rd_data == key);
  assign more   = (scan_idx != used_count);
  assign full   = (used_count == CNT_W'(TABLE_CAPACITY));
  assign insert = cmd.finish && !hit && !full;

  assign status.match     = match;
  assign status.scan_done = !more && !rd_valid;
  assign status.out_free  = !out_valid || out_ready;

  // Table memory: write on insert, registered read during the scan
  always_ff @(posedge clk) begin
    if (insert) begin
      key_table[used_count[IDX_W-1:0]] <= key;
    end
    if (cmd.scan && more) begin
      rd_data <= key_table[scan_idx[IDX_W-1:0]];
    end
  end

  // Latch the key and track the scan position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= {coord_x, coord_y, coord_z};
    end
    if (cmd.scan && more) begin
      rd_idx <= scan_idx[IDX_W-1:0];
    end
    if (cmd.scan && match) begin
      hit_idx <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      rd_valid   <= 1'b0;
      hit        <= 1'b0;
      used_count <= '0;
    end else begin
      if (cmd.start) begin
        scan_idx <= '0;
        rd_valid <= 1'b0;
        hit      <= 1'b0;
      end else if (cmd.scan) begin
        rd_valid <= more;
        if (more) begin
          scan_idx <= scan_idx + CNT_W'(1);
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (insert) begin
        used_count <= used_count + CNT_W'(1);
      end
    end
  end

  // Pick the index to report
  always_comb begin
    if (hit) begin
      res_idx = hit_idx;
    end else if (full) begin
      res_idx = '0;
    end else begin
      res_idx = used_count[IDX_W-1:0];
    end
    res_ext = EXT_W'(res_idx);
  end

  // Result register: load on finish, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      vertex_index <= res_ext[INDEX_W-1:0];
      was_new      <= !hit && !full;
      overflow     <= !hit && full;
    end
  end

endmodule
`default_nettype wire

// ===== src/vertex_dedup_index_table_unit.sv =====
// Vertex index table: returns a unique index for each distinct (x, y, z) triple.
// Input channel "vertex" carries three 64-bit coordinate bit patterns per beat;
// output channel "result" carries vertex_index, was_new and overflow, one beat
// per input beat, in order. Both channels use valid/ready.
// A vertex is taken only while the unit is idle. The stored keys are read one
// entry per cycle through the table memory's single registered read port, so
// a hit ends the scan at the matching entry and a miss reads every used entry
// first; on an empty table no entry is read (the insert write lands in the
// same cycle as the result).
// The next vertex is taken in the cycle after the result is loaded, whether
// or not that result has been taken.
// A miss on a full table stores nothing and reports index 0 with overflow set.
// If the receiver stalls, the result register holds its beat; a finished scan
// then waits for the register to free up before loading the next result.
// Reset empties the table (the used count goes to zero at once, no clearing
// pass) and drops any result that was waiting.
`default_nettype none
module vertex_dedup_index_table_unit
  import vdit_pkg::*;
#(
  parameter int unsigned TABLE_CAPACITY = TABLE_CAPACITY_DEF
) (
  input wire logic     clk,
  input wire logic     rst,
  vdit_vertex_if.sink  vertex,
  vdit_result_if.source result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  vdit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vertex.valid),
    .in_ready (vertex.ready),
    .status   (status),
    .cmd      (cmd)
  );

  vdit_datapath #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .coord_x      (vertex.coord_x),
    .coord_y      (vertex.coord_y),
    .coord_z      (vertex.coord_z),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .vertex_index (result.vertex_index),
    .was_new      (result.was_new),
    .overflow     (result.overflow)
  );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import vdit_pkg::*;

  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned PRESS_AT     = 150;
  localparam int unsigned PRESS_HOLD   = 800;
  localparam int unsigned RANDOM_ITEMS = 490;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam logic [COORD_W-1:0] ALL_ONES  = '1;
  localparam logic [COORD_W-1:0] NEG_ZERO  = 64'h8000_0000_0000_0000;
  localparam logic [COORD_W-1:0] QUIET_NAN = 64'h7FF8_0000_0000_0000;
  localparam logic [COORD_W-1:0] OTHER_NAN = 64'h7FF8_0000_0000_0001;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               was_new;
    logic               overflow;
  } index_result_t;

  typedef struct {
    vertex_t       v;
    bit            typed;
    index_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vdit_vertex_if vtx_bus ();
  vdit_result_if res_bus ();

  vertex_dedup_index_table_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .vertex (vtx_bus),
    .result (res_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the key table
  logic [COORD_W-1:0] known_x [TABLE_CAPACITY_DEF];
  logic [COORD_W-1:0] known_y [TABLE_CAPACITY_DEF];
  logic [COORD_W-1:0] known_z [TABLE_CAPACITY_DEF];
  int unsigned        known_count = 0;

  index_result_t expected_indices [$];
  vertex_t       sent_vertices [$];
  stim_row_t     directed_rows [$];
  int unsigned   vertices_taken = 0;
  int unsigned   errors = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   cycle_count = 0;

  // Look up a vertex, insert it on a miss while there is room
  function automatic index_result_t assign_index(vertex_t v);
    index_result_t r;
    r = '0;
    for (int unsigned i = 0; i < known_count; i++) begin
      if (known_x[i] == v.x && known_y[i] == v.y && known_z[i] == v.z) begin
        r.vertex_index = i[INDEX_W-1:0];
        return r;
      end
    end
    if (known_count >= TABLE_CAPACITY_DEF) begin
      r.overflow = 1'b1;
      return r;
    end
    known_x[known_count] = v.x;
    known_y[known_count] = v.y;
    known_z[known_count] = v.z;
    r.vertex_index = known_count[INDEX_W-1:0];
    r.was_new = 1'b1;
    known_count++;
    return r;
  endfunction

  function automatic void add_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                  logic [COORD_W-1:0] z, bit typed,
                                  int unsigned idx, bit was_new, bit ovf);
    stim_row_t row;
    row.v = '{x: x, y: y, z: z};
    row.typed = typed;
    row.want = '{vertex_index: idx[INDEX_W-1:0], was_new: was_new, overflow: ovf};
    directed_rows.push_back(row);
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    case ($urandom_range(11))
      0: return '0;
      1: return ALL_ONES;
      2: return NEG_ZERO;
      3: return QUIET_NAN;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("%s", msg);
  endtask

  // Offer one vertex beat and record its expected index once taken
  task automatic offer_vertex(vertex_t v, bit typed, index_result_t typed_want,
                              int unsigned gap);
    index_result_t predicted;
    @(negedge clk);
    if (gap != 0) begin
      vtx_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    vtx_bus.valid   <= 1'b1;
    vtx_bus.coord_x <= v.x;
    vtx_bus.coord_y <= v.y;
    vtx_bus.coord_z <= v.z;
    @(posedge clk);
    while (!vtx_bus.ready) @(posedge clk);
    predicted = assign_index(v);
    expected_indices.push_back(typed ? typed_want : predicted);
    sent_vertices.push_back(v);
    vertices_taken++;
  endtask

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((vtx_bus.valid && vtx_bus.ready) || (res_bus.valid && res_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    index_result_t got_r;
    index_result_t want_r;
    if (!rst && res_bus.valid && res_bus.ready) begin
      got_r = '{vertex_index: res_bus.vertex_index, was_new: res_bus.was_new,
                overflow: res_bus.overflow};
      if (expected_indices.size() == 0) begin
        note_error($sformatf("unexpected result beat: index %0d new %0b ovf %0b",
                             got_r.vertex_index, got_r.was_new, got_r.overflow));
      end else begin
        want_r = expected_indices.pop_front();
        if (got_r !== want_r)
          note_error($sformatf(
            "mismatch: expected index %0d new %0b ovf %0b, got index %0d new %0b ovf %0b",
            want_r.vertex_index, want_r.was_new, want_r.overflow,
            got_r.vertex_index, got_r.was_new, got_r.overflow));
      end
    end
  end

  // Drive result ready: random stalls, calm stretches, one long hold-off
  initial begin : result_ready_drive
    int unsigned stall;
    bit pressed;
    pressed = 1'b0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && vertices_taken >= PRESS_AT) begin
        pressed = 1'b1;
        res_bus.ready <= 1'b0;
        repeat (PRESS_HOLD) @(negedge clk);
        res_bus.ready <= 1'b1;
      end else begin
        stall = pick_gap((cycle_count / 300) % 5 == 2);
        if (stall != 0) begin
          res_bus.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    vertex_t v;
    int unsigned roll;
    int unsigned pick;
    int unsigned bitpos;

    vtx_bus.valid   = 1'b0;
    vtx_bus.coord_x = '0;
    vtx_bus.coord_y = '0;
    vtx_bus.coord_z = '0;

    // Directed rows: extremes, signed zero, NaN patterns, single-field differences
    add_row('0, '0, '0, 1, 0, 1, 0);
    add_row('0, '0, '0, 1, 0, 0, 0);
    add_row(ALL_ONES, ALL_ONES, ALL_ONES, 1, 1, 1, 0);
    add_row('0, '0, NEG_ZERO, 1, 2, 1, 0);
    add_row(QUIET_NAN, QUIET_NAN, QUIET_NAN, 1, 3, 1, 0);
    add_row(QUIET_NAN, QUIET_NAN, QUIET_NAN, 1, 3, 0, 0);
    add_row(OTHER_NAN, QUIET_NAN, QUIET_NAN, 1, 4, 1, 0);
    add_row(ALL_ONES, ALL_ONES, ALL_ONES, 1, 1, 0, 0);
    add_row(64'd1, 64'd2, 64'd3, 0, 0, 0, 0);
    add_row(64'd3, 64'd2, 64'd1, 0, 0, 0, 0);
    add_row(64'd1, 64'd2, 64'd4, 0, 0, 0, 0);
    add_row(64'd1, 64'd5, 64'd3, 0, 0, 0, 0);
    add_row(64'd1, 64'd2, 64'd3, 0, 0, 0, 0);
    add_row(NEG_ZERO, '0, '0, 0, 0, 0, 0);
    add_row('0, NEG_ZERO, '0, 0, 0, 0, 0);
    add_row(ALL_ONES, ALL_ONES, 64'hFFFF_FFFF_FFFF_FFFE, 0, 0, 0, 0);

    // Hold reset, then release it
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      offer_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want,
                   pick_gap(1'b0));

    // Random part: mostly fresh keys to fill the table, plus repeats and near misses
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(99);
      pick = $urandom_range(sent_vertices.size() - 1);
      v = sent_vertices[pick];
      if (roll < 55) begin
        v.x = random_coord();
        v.y = random_coord();
        v.z = random_coord();
      end else if (roll < 70) begin
        bitpos = $urandom_range(COORD_W - 1);
        case ($urandom_range(2))
          0: v.x[bitpos] = ~v.x[bitpos];
          1: v.y[bitpos] = ~v.y[bitpos];
          default: v.z[bitpos] = ~v.z[bitpos];
        endcase
      end
      offer_vertex(v, 1'b0, '0, pick_gap((n / 40) % 5 == 4));
    end

    @(negedge clk);
    vtx_bus.valid <= 1'b0;

    // Drain, then let the block run out its latency
    wait (expected_indices.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
